### rtl/rv64eu_pkg.sv
// ----------------------------------------------------------------------------
// rv64eu_pkg
// Shared types, opcodes, CSR addresses and reset values of the RV64I execute
// unit.
// ----------------------------------------------------------------------------
package rv64eu_pkg;

  localparam int unsigned XLEN            = 64;
  localparam int unsigned RegCountDefault = 32;
  localparam int unsigned CsrCountDefault = 4096;

  localparam logic [XLEN-1:0] PcResetValue = 64'h0000_0000_8000_0000;
  localparam logic [XLEN-1:0] SpResetValue = 64'h0000_0000_87FF_FFFF;
  localparam logic [XLEN-1:0] MemBaseReset = 64'h0000_0000_8000_0000;
  localparam int unsigned     SpIndex      = 2;

  typedef enum logic [6:0] {
    OPC_LUI       = 7'h37,
    OPC_AUIPC     = 7'h17,
    OPC_JAL       = 7'h6f,
    OPC_JALR      = 7'h67,
    OPC_BRANCH    = 7'h63,
    OPC_LOAD      = 7'h03,
    OPC_STORE     = 7'h23,
    OPC_OP_IMM    = 7'h13,
    OPC_OP        = 7'h33,
    OPC_SYSTEM    = 7'h73,
    OPC_OP_IMM_32 = 7'h1b,
    OPC_OP_32     = 7'h3b
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ILLEGAL   = 2'd1,
    STATUS_BUS_FAULT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_req_e;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // load kinds
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_LWU = 3'd6;
  localparam logic [2:0] F3_LD_BAD = 3'd7;

  // system funct3
  localparam logic [2:0] F3_PRIV    = 3'd0;
  localparam logic [2:0] F3_SYS_BAD = 3'd4;
  localparam logic [1:0] CSR_OP_RW  = 2'd1;
  localparam logic [1:0] CSR_OP_RS  = 2'd2;
  localparam logic [1:0] CSR_OP_RC  = 2'd3;

  localparam logic [4:0] RS2_XRET  = 5'd2;
  localparam logic [6:0] F7_SRET   = 7'h08;
  localparam logic [6:0] F7_MRET   = 7'h18;

  localparam logic [11:0] CSR_SSTATUS = 12'h100;
  localparam logic [11:0] CSR_SIE     = 12'h104;
  localparam logic [11:0] CSR_SEPC    = 12'h141;
  localparam logic [11:0] CSR_SIP     = 12'h144;
  localparam logic [11:0] CSR_MSTATUS = 12'h300;
  localparam logic [11:0] CSR_MIDELEG = 12'h303;
  localparam logic [11:0] CSR_MIE     = 12'h304;
  localparam logic [11:0] CSR_MEPC    = 12'h341;
  localparam logic [11:0] CSR_MIP     = 12'h344;

  localparam logic [XLEN-1:0] SstatusMask = 64'h8000_0003_000D_E162;

  typedef struct packed {
    logic [XLEN-1:0] opa;
    logic [XLEN-1:0] opb;
    logic [2:0]      funct3;
    logic            sub;
    logic            arith;
    logic            word;
  } alu_req_t;

endpackage

### rtl/rv64eu_alu.sv
// ----------------------------------------------------------------------------
// rv64eu_alu
// Integer ALU for OP, OP-IMM and their 32-bit word forms.
// ----------------------------------------------------------------------------
module rv64eu_alu import rv64eu_pkg::*; (
  input  alu_req_t        req_i,
  output logic [XLEN-1:0] result_o
);

  logic [XLEN-1:0] sum;
  logic [XLEN-1:0] sra64;
  logic [31:0]     lo;
  logic [31:0]     w_sll;
  logic [31:0]     w_srl;
  logic [31:0]     w_sra;
  logic [5:0]      sh64;
  logic [4:0]      sh32;
  logic            lt_s;

  assign sh64  = req_i.opb[5:0];
  assign sh32  = req_i.opb[4:0];
  assign lo    = req_i.opa[31:0];
  assign sum   = req_i.sub ? req_i.opa - req_i.opb : req_i.opa + req_i.opb;
  assign sra64 = XLEN'($signed(req_i.opa) >>> sh64);
  assign w_sll = lo << sh32;
  assign w_srl = lo >> sh32;
  assign w_sra = 32'($signed(lo) >>> sh32);
  assign lt_s  = $signed(req_i.opa) < $signed(req_i.opb);

  always_comb begin
    result_o = '0;
    if (req_i.word) begin
      case (req_i.funct3)
        F3_ADD:  result_o = {{32{sum[31]}}, sum[31:0]};
        F3_SLL:  result_o = {{32{w_sll[31]}}, w_sll};
        F3_SR: begin
          if (req_i.arith) result_o = {{32{w_sra[31]}}, w_sra};
          else             result_o = {{32{w_srl[31]}}, w_srl};
        end
        default: result_o = '0;
      endcase
    end else begin
      case (req_i.funct3)
        F3_ADD:  result_o = sum;
        F3_SLL:  result_o = req_i.opa << sh64;
        F3_SLT:  result_o = {{(XLEN-1){1'b0}}, lt_s};
        F3_SLTU: result_o = {{(XLEN-1){1'b0}}, req_i.opa < req_i.opb};
        F3_XOR:  result_o = req_i.opa ^ req_i.opb;
        F3_SR:   result_o = req_i.arith ? sra64 : req_i.opa >> sh64;
        F3_OR:   result_o = req_i.opa | req_i.opb;
        default: result_o = req_i.opa & req_i.opb;
      endcase
    end
  end

endmodule

### rtl/rv64eu_regfile.sv
// ----------------------------------------------------------------------------
// rv64eu_regfile
// Integer register file: two registered read ports with write bypass, one
// write port, per-entry valid bits standing in for the reset values.
// ----------------------------------------------------------------------------
module rv64eu_regfile import rv64eu_pkg::*; #(
  parameter int unsigned REG_COUNT = RegCountDefault,
  localparam int unsigned AW = $clog2(REG_COUNT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rs1_addr_i,
  input  logic [AW-1:0]   rs2_addr_i,
  output logic [XLEN-1:0] rs1_data_o,
  output logic [XLEN-1:0] rs2_data_o,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [XLEN-1:0] wdata_i
);

  typedef enum logic [1:0] {
    RF_MEM    = 2'd0,
    RF_BYPASS = 2'd1,
    RF_ZERO   = 2'd2,
    RF_SP     = 2'd3
  } rf_src_e;

  logic [XLEN-1:0] regs_q [REG_COUNT];
  logic [REG_COUNT-1:0] valid_q;
  logic [XLEN-1:0] rs1_mem_q, rs2_mem_q, byp_q;
  rf_src_e         rs1_src_q, rs2_src_q;
  rf_src_e         rs1_src_d, rs2_src_d;

  function automatic rf_src_e pick_src(logic [AW-1:0] addr, logic we,
                                       logic [AW-1:0] waddr,
                                       logic [REG_COUNT-1:0] valid);
    rf_src_e src;
    if (addr == '0)                  src = RF_ZERO;
    else if (we && waddr == addr)    src = RF_BYPASS;
    else if (valid[addr])            src = RF_MEM;
    else if (addr == AW'(SpIndex))   src = RF_SP;
    else                             src = RF_ZERO;
    return src;
  endfunction

  assign rs1_src_d = pick_src(rs1_addr_i, we_i, waddr_i, valid_q);
  assign rs2_src_d = pick_src(rs2_addr_i, we_i, waddr_i, valid_q);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      regs_q[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rs1_mem_q <= regs_q[rs1_addr_i];
      rs2_mem_q <= regs_q[rs2_addr_i];
      byp_q     <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rs1_src_q <= RF_ZERO;
      rs2_src_q <= RF_ZERO;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rs1_src_q <= rs1_src_d;
        rs2_src_q <= rs2_src_d;
      end
    end
  end

  always_comb begin
    case (rs1_src_q)
      RF_MEM:    rs1_data_o = rs1_mem_q;
      RF_BYPASS: rs1_data_o = byp_q;
      RF_SP:     rs1_data_o = SpResetValue;
      default:   rs1_data_o = '0;
    endcase
    case (rs2_src_q)
      RF_MEM:    rs2_data_o = rs2_mem_q;
      RF_BYPASS: rs2_data_o = byp_q;
      RF_SP:     rs2_data_o = SpResetValue;
      default:   rs2_data_o = '0;
    endcase
  end

endmodule

### rtl/rv64eu_csr_mem.sv
// ----------------------------------------------------------------------------
// rv64eu_csr_mem
// Generic CSR storage: single-port write, registered read with write bypass,
// zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module rv64eu_csr_mem import rv64eu_pkg::*; #(
  parameter int unsigned CSR_COUNT = CsrCountDefault,
  localparam int unsigned AW = $clog2(CSR_COUNT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  output logic            ready_o,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [XLEN-1:0] rdata_o,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [XLEN-1:0] wdata_i
);

  logic [XLEN-1:0] mem_q [CSR_COUNT];
  logic [AW-1:0]   clr_addr_q;
  logic            clr_busy_q;
  logic            port_we;
  logic [AW-1:0]   port_addr;
  logic [XLEN-1:0] port_data;
  logic [XLEN-1:0] rd_mem_q, byp_q;
  logic            byp_sel_q;

  assign ready_o   = !clr_busy_q;
  assign port_we   = clr_busy_q || we_i;
  assign port_addr = clr_busy_q ? clr_addr_q : waddr_i;
  assign port_data = clr_busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
      byp_sel_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(CSR_COUNT - 1)) clr_busy_q <= 1'b0;
      end
      if (rd_en_i) byp_sel_q <= we_i && (waddr_i == raddr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (port_we) mem_q[port_addr] <= port_data;
    if (rd_en_i) begin
      rd_mem_q <= mem_q[raddr_i];
      byp_q    <= wdata_i;
    end
  end

  assign rdata_o = byp_sel_q ? byp_q : rd_mem_q;

endmodule

### rtl/rv64i_execute_unit.sv
// ----------------------------------------------------------------------------
// rv64i_execute_unit
// RV64I + Zicsr execute unit: one instruction or load-data return per request.
// ----------------------------------------------------------------------------
// One request is taken per clock while s_axis_tready is high (CSR sweep done,
// result register empty or being read). A request is latched into the input
// stage together with its register-file and CSR reads (both synchronous
// memories read at the edge that accepts it), executed from there and handed
// to the result register, so a new request can enter while the previous one
// executes. After reset the generic CSR storage is swept to zero, which keeps
// s_axis_tready low until every CSR entry is cleared; memory_base writes are
// taken at any time. Loads leave as a load request and finish when the load
// data comes back as a request with tuser set; stores leave as a store
// request carrying rs2. Addresses below memory_base give a bus fault and
// unknown encodings an illegal status, both leaving all state unchanged.
// ----------------------------------------------------------------------------
module rv64i_execute_unit import rv64eu_pkg::*; #(
  parameter int unsigned REG_COUNT = RegCountDefault,
  parameter int unsigned CSR_COUNT = CsrCountDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // memory_base register
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,
  // requests in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: instruction [31:0], load_data [95:32]
  input  logic [95:0]  s_axis_tdata,
  // tuser: cmd [0]
  input  logic [0:0]   s_axis_tuser,
  // results out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: next_pc [63:0], mem_address [127:64], mem_size [129:128],
  //        store_value [193:130], reg_write [194], reg_index [199:195],
  //        reg_value [263:200]
  output logic [263:0] m_axis_tdata,
  // tuser: mem_request [1:0], status [3:2]
  output logic [3:0]   m_axis_tuser
);

  localparam int unsigned RAW = $clog2(REG_COUNT);
  localparam int unsigned CAW = $clog2(CSR_COUNT);

  // --------------------------------------------------------------------------
  // handshake and input stage
  // --------------------------------------------------------------------------
  logic        csr_ready;
  logic        advance, accept, fire, commit;
  logic        s1_valid_q, s1_cmd_q;
  logic [31:0] s1_ins_q;
  logic [63:0] s1_ldata_q;

  // the result register frees up this cycle, or is already empty
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = csr_ready && advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= s_axis_tuser[0];
      s1_ins_q   <= s_axis_tdata[31:0];
      s1_ldata_q <= s_axis_tdata[95:32];
    end
  end

  // --------------------------------------------------------------------------
  // architectural state
  // --------------------------------------------------------------------------
  logic [63:0] mem_base_q, pc_q;
  logic [63:0] mstatus_q, mideleg_q, mie_q, mip_q, mepc_q, sepc_q;
  logic [1:0]  priv_q;
  logic        load_pending_q;
  logic [4:0]  pend_dest_q;
  logic [2:0]  pend_kind_q;

  logic [63:0] rs1_data, rs2_data;
  logic        rf_we;
  logic [63:0] csr_mem_rdata;
  logic        csr_mem_we;

  // --------------------------------------------------------------------------
  // decode fields
  // --------------------------------------------------------------------------
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd, rs1, rs2;
  logic        alt;
  logic [11:0] csr_addr;
  logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;

  assign opc      = s1_ins_q[6:0];
  assign rd       = s1_ins_q[11:7];
  assign f3       = s1_ins_q[14:12];
  assign rs1      = s1_ins_q[19:15];
  assign rs2      = s1_ins_q[24:20];
  assign f7       = s1_ins_q[31:25];
  assign alt      = s1_ins_q[30];
  assign csr_addr = s1_ins_q[31:20];
  assign imm_i    = {{52{s1_ins_q[31]}}, s1_ins_q[31:20]};
  assign imm_s    = {{52{s1_ins_q[31]}}, s1_ins_q[31:25], s1_ins_q[11:7]};
  assign imm_b    = {{51{s1_ins_q[31]}}, s1_ins_q[31], s1_ins_q[7], s1_ins_q[30:25],
                     s1_ins_q[11:8], 1'b0};
  assign imm_j    = {{43{s1_ins_q[31]}}, s1_ins_q[31], s1_ins_q[19:12], s1_ins_q[20],
                     s1_ins_q[30:21], 1'b0};
  assign imm_u    = {{32{s1_ins_q[31]}}, s1_ins_q[31:12], 12'b0};

  // --------------------------------------------------------------------------
  // storage
  // --------------------------------------------------------------------------
  logic [4:0]  rf_waddr;
  logic [63:0] rf_wdata;

  rv64eu_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rs1_addr_i (s_axis_tdata[15 +: RAW]),
    .rs2_addr_i (s_axis_tdata[20 +: RAW]),
    .rs1_data_o (rs1_data),
    .rs2_data_o (rs2_data),
    .we_i       (rf_we),
    .waddr_i    (rf_waddr[RAW-1:0]),
    .wdata_i    (rf_wdata)
  );

  logic [63:0] csr_wv;

  rv64eu_csr_mem #(
    .CSR_COUNT (CSR_COUNT)
  ) u_csr_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ready_o (csr_ready),
    .rd_en_i (accept),
    .raddr_i (s_axis_tdata[20 +: CAW]),
    .rdata_o (csr_mem_rdata),
    .we_i    (csr_mem_we),
    .waddr_i (csr_addr[CAW-1:0]),
    .wdata_i (csr_wv)
  );

  // --------------------------------------------------------------------------
  // ALU
  // --------------------------------------------------------------------------
  alu_req_t    alu_req;
  logic [63:0] alu_res;

  rv64eu_alu u_alu (
    .req_i    (alu_req),
    .result_o (alu_res)
  );

  always_comb begin
    alu_req.opa    = rs1_data;
    alu_req.opb    = (opc == OPC_OP || opc == OPC_OP_32) ? rs2_data : imm_i;
    alu_req.funct3 = f3;
    alu_req.sub    = alt && (opc == OPC_OP || opc == OPC_OP_32);
    alu_req.arith  = alt;
    alu_req.word   = (opc == OPC_OP_IMM_32 || opc == OPC_OP_32);
  end

  // --------------------------------------------------------------------------
  // CSR read view: sstatus, sie and sip are masked windows onto machine ones
  // --------------------------------------------------------------------------
  logic [63:0] csr_rd, csr_src;
  logic        csr_special;

  always_comb begin
    csr_special = 1'b1;
    case (csr_addr)
      CSR_SIE:     csr_rd = mie_q & mideleg_q;
      CSR_SIP:     csr_rd = mip_q & mideleg_q;
      CSR_SSTATUS: csr_rd = mstatus_q & SstatusMask;
      CSR_MSTATUS: csr_rd = mstatus_q;
      CSR_MIDELEG: csr_rd = mideleg_q;
      CSR_MIE:     csr_rd = mie_q;
      CSR_MIP:     csr_rd = mip_q;
      CSR_MEPC:    csr_rd = mepc_q;
      CSR_SEPC:    csr_rd = sepc_q;
      default: begin
        csr_rd      = csr_mem_rdata;
        csr_special = 1'b0;
      end
    endcase
    csr_src = f3[2] ? {59'b0, rs1} : rs1_data;
    case (f3[1:0])
      CSR_OP_RW: csr_wv = csr_src;
      CSR_OP_RS: csr_wv = csr_rd | csr_src;
      CSR_OP_RC: csr_wv = csr_rd & ~csr_src;
      default:   csr_wv = csr_rd;
    endcase
  end

  // --------------------------------------------------------------------------
  // execute
  // --------------------------------------------------------------------------
  logic [63:0] npc, eff_addr, wv, ld_ext;
  logic        wr, bad, fault, ld_start, ld_done, csr_we, do_sret, do_mret, taken;
  logic        is_store;

  assign is_store = (opc == OPC_STORE);
  assign eff_addr = rs1_data + (is_store ? imm_s : imm_i);

  // extend returning load data by the kind recorded with the request
  always_comb begin
    case (pend_kind_q)
      F3_LB:   ld_ext = {{56{s1_ldata_q[7]}}, s1_ldata_q[7:0]};
      F3_LH:   ld_ext = {{48{s1_ldata_q[15]}}, s1_ldata_q[15:0]};
      F3_LW:   ld_ext = {{32{s1_ldata_q[31]}}, s1_ldata_q[31:0]};
      F3_LBU:  ld_ext = {56'b0, s1_ldata_q[7:0]};
      F3_LHU:  ld_ext = {48'b0, s1_ldata_q[15:0]};
      F3_LWU:  ld_ext = {32'b0, s1_ldata_q[31:0]};
      default: ld_ext = s1_ldata_q;
    endcase
  end

  always_comb begin
    case (f3)
      F3_BEQ:  taken = rs1_data == rs2_data;
      F3_BNE:  taken = rs1_data != rs2_data;
      F3_BLT:  taken = $signed(rs1_data) < $signed(rs2_data);
      F3_BGE:  taken = $signed(rs1_data) >= $signed(rs2_data);
      F3_BLTU: taken = rs1_data < rs2_data;
      F3_BGEU: taken = rs1_data >= rs2_data;
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    npc      = pc_q + 64'd4;
    wv       = '0;
    wr       = 1'b0;
    bad      = 1'b0;
    fault    = 1'b0;
    ld_start = 1'b0;
    ld_done  = 1'b0;
    csr_we   = 1'b0;
    do_sret  = 1'b0;
    do_mret  = 1'b0;
    rf_waddr = rd;
    if (s1_cmd_q) begin
      // load data return: the pc holds
      npc = pc_q;
      if (load_pending_q) begin
        ld_done  = 1'b1;
        wr       = 1'b1;
        wv       = ld_ext;
        rf_waddr = pend_dest_q;
      end
    end else begin
      case (opcode_e'(opc))
        OPC_LUI: begin
          wr = 1'b1;
          wv = imm_u;
        end
        OPC_AUIPC: begin
          wr = 1'b1;
          wv = pc_q + imm_u;
        end
        OPC_JAL: begin
          wr  = 1'b1;
          wv  = pc_q + 64'd4;
          npc = pc_q + imm_j;
        end
        OPC_JALR: begin
          // target is rs1 plus the I immediate, whatever funct3 holds
          wr  = 1'b1;
          wv  = pc_q + 64'd4;
          npc = {eff_addr[63:1], 1'b0};
        end
        OPC_BRANCH: begin
          if (f3 == F3_SLT || f3 == F3_SLTU) bad = 1'b1;
          else if (taken) npc = pc_q + imm_b;
        end
        OPC_LOAD, OPC_STORE: begin
          if ((!is_store && f3 == F3_LD_BAD) || (is_store && f3[2])) bad = 1'b1;
          else if (eff_addr < mem_base_q) fault = 1'b1;
          else ld_start = !is_store;
        end
        OPC_OP_IMM, OPC_OP: begin
          wr = 1'b1;
          wv = alu_res;
        end
        OPC_OP_IMM_32, OPC_OP_32: begin
          if (f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SR) begin
            wr = 1'b1;
            wv = alu_res;
          end else begin
            bad = 1'b1;
          end
        end
        OPC_SYSTEM: begin
          if (f3 == F3_PRIV) begin
            // ECALL, EBREAK and SFENCE.VMA fall through as no-ops
            if (rs2 == RS2_XRET && f7 == F7_SRET) begin
              do_sret = 1'b1;
              npc     = {sepc_q[63:2], 2'b0};
            end else if (rs2 == RS2_XRET && f7 == F7_MRET) begin
              do_mret = 1'b1;
              npc     = {mepc_q[63:2], 2'b0};
            end
          end else if (f3 == F3_SYS_BAD) begin
            bad = 1'b1;
          end else begin
            csr_we = 1'b1;
            wr     = 1'b1;
            wv     = csr_rd;
          end
        end
        default: bad = 1'b1;
      endcase
    end
  end

  assign commit     = fire && !bad && !fault;
  assign rf_we      = commit && wr && (rf_waddr != 5'd0);
  assign rf_wdata   = wv;
  assign csr_mem_we = commit && csr_we && !csr_special;

  // --------------------------------------------------------------------------
  // state update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_base_q     <= MemBaseReset;
      pc_q           <= PcResetValue;
      mstatus_q      <= '0;
      mideleg_q      <= '0;
      mie_q          <= '0;
      mip_q          <= '0;
      mepc_q         <= '0;
      sepc_q         <= '0;
      priv_q         <= 2'd3;
      load_pending_q <= 1'b0;
      pend_dest_q    <= '0;
      pend_kind_q    <= '0;
    end else begin
      if (cfg_we_i) mem_base_q <= cfg_wdata_i;
      if (commit) begin
        pc_q <= npc;
        if (ld_start) begin
          load_pending_q <= 1'b1;
          pend_dest_q    <= rd;
          pend_kind_q    <= f3;
        end else if (ld_done) begin
          load_pending_q <= 1'b0;
        end
        if (do_sret) begin
          priv_q       <= {1'b0, mstatus_q[8]};
          mstatus_q[1] <= mstatus_q[5];
          mstatus_q[5] <= 1'b1;
          mstatus_q[8] <= 1'b0;
        end
        if (do_mret) begin
          priv_q           <= mstatus_q[12:11];
          mstatus_q[3]     <= mstatus_q[7];
          mstatus_q[7]     <= 1'b1;
          mstatus_q[12:11] <= 2'b00;
          if (mstatus_q[12:11] != 2'd3) mstatus_q[17] <= 1'b0;
        end
        if (csr_we) begin
          case (csr_addr)
            CSR_SIE:     mie_q <= (mie_q & ~mideleg_q) | (csr_wv & mideleg_q);
            CSR_SIP:     mip_q <= (mip_q & ~mideleg_q) | (csr_wv & mideleg_q);
            CSR_SSTATUS: mstatus_q <= (mstatus_q & ~SstatusMask) | (csr_wv & SstatusMask);
            CSR_MSTATUS: mstatus_q <= csr_wv;
            CSR_MIDELEG: mideleg_q <= csr_wv;
            CSR_MIE:     mie_q     <= csr_wv;
            CSR_MIP:     mip_q     <= csr_wv;
            CSR_MEPC:    mepc_q    <= csr_wv;
            CSR_SEPC:    sepc_q    <= csr_wv;
            default:     ;
          endcase
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic        out_valid_q;
  logic [63:0] out_npc_q, out_addr_q, out_store_q, out_value_q;
  logic [1:0]  out_size_q;
  logic        out_write_q;
  logic [4:0]  out_index_q;
  mem_req_e    out_req_q;
  status_e     out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_npc_q    <= commit ? npc : pc_q;
      out_status_q <= bad ? STATUS_ILLEGAL : (fault ? STATUS_BUS_FAULT : STATUS_OK);
      out_write_q  <= rf_we;
      out_index_q  <= rf_we ? rf_waddr : 5'd0;
      out_value_q  <= rf_we ? wv : '0;
      if (commit && !s1_cmd_q && (opc == OPC_LOAD || opc == OPC_STORE)) begin
        out_req_q   <= is_store ? MEM_STORE : MEM_LOAD;
        out_addr_q  <= eff_addr;
        out_size_q  <= f3[1:0];
        out_store_q <= is_store ? rs2_data : '0;
      end else begin
        out_req_q   <= MEM_NONE;
        out_addr_q  <= '0;
        out_size_q  <= '0;
        out_store_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_value_q, out_index_q, out_write_q, out_store_q,
                          out_size_q, out_addr_q, out_npc_q};
  assign m_axis_tuser  = {out_status_q, out_req_q};

`ifndef SYNTH
  // a faulting or illegal result never carries a write or a memory request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != STATUS_OK) |-> (!out_write_q && out_req_q == MEM_NONE))
    else $error("error result carries side effects");

  // x0 is never reported as written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_write_q) |-> (out_index_q != 5'd0))
    else $error("write to x0 reported");

  // an issued load leaves a pending load behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && ld_start) |=> load_pending_q)
    else $error("load issued without pending state");

  // no request enters while the CSR sweep runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !csr_ready |=> !s1_valid_q)
    else $error("request accepted during CSR sweep");
`endif

endmodule
